// File: hw/rtl/nvt_pkg.sv
package nvt_pkg;

  localparam int NAME_MAX_LEN  = 256;
  localparam int VALUE_MAX_LEN = 2048;

  localparam int NAME_CNT_W  = $clog2(NAME_MAX_LEN + 1);
  localparam int VALUE_CNT_W = $clog2(VALUE_MAX_LEN + 1);

  localparam int BYTE_W      = 8;
  localparam int NAME_LEN_W  = 8;
  localparam int VALUE_LEN_W = 11;

  typedef logic [1:0] role_t;
  localparam role_t ROLE_SKIP  = 2'd0;
  localparam role_t ROLE_NAME  = 2'd1;
  localparam role_t ROLE_VALUE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_NONE  = 2'd0;
  localparam status_t ST_PAIR  = 2'd1;
  localparam status_t ST_ERROR = 2'd2;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_EQUAL = 8'h3D;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_NAME,
    PH_VLEAD,
    PH_PLAIN,
    PH_QUOTED,
    PH_AFTERQ,
    PH_HALT
  } phase_t;

  // space, TAB, LF, VT, FF, CR
  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

// File: hw/rtl/nvt_if.sv
interface nvt_byte_if;
  logic                      valid;
  logic                      ready;
  logic [nvt_pkg::BYTE_W-1:0] data_byte;
  logic                      buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface nvt_token_if;
  logic                           valid;
  logic                           ready;
  nvt_pkg::role_t                 byte_role;
  logic [nvt_pkg::BYTE_W-1:0]     echo_byte;
  nvt_pkg::status_t               status;
  logic                           has_value;
  logic [nvt_pkg::NAME_LEN_W-1:0] name_length;
  logic [nvt_pkg::VALUE_LEN_W-1:0] value_length;
  logic                           end_seen;

  modport source (output valid, output byte_role, output echo_byte, output status,
                  output has_value, output name_length, output value_length,
                  output end_seen, input ready);
  modport sink   (input valid, input byte_role, input echo_byte, input status,
                  input has_value, input name_length, input value_length,
                  input end_seen, output ready);
endinterface

// File: hw/rtl/name_value_list_tokenizer.sv
// Name/value list tokenizer.
// The bytes channel takes one buffer byte per request with buffer_end set on
// the last byte. The tokens channel returns one result per byte: the role of
// the byte (skipped, name, value), the byte itself, and on the byte that
// completes a pair its trimmed name and value lengths. A parse error (byte
// after a closing quote that is not a comma or CR, over-long name or value)
// gives status error; later bytes are ignored until a byte with buffer_end.
// A byte passes from the input register, which takes it when the request is
// accepted, to the result register, which the phase update loads. Throughput
// is one byte per cycle while the tokens receiver does not stall; the phase
// and length counters are updated in one step.
// Reset puts the parser in the separator-skipping phase with all counters
// cleared and both register stages empty. When the tokens receiver stalls,
// the result register holds, the input register still fills, and bytes.ready
// drops only once both stages are full.
module name_value_list_tokenizer (
  input  logic              clk,
  input  logic              rst,
  nvt_byte_if.sink          bytes,
  nvt_token_if.source       tokens
);
  import nvt_pkg::*;

  localparam logic [NAME_CNT_W-1:0]  NAME_MAX  = NAME_CNT_W'(NAME_MAX_LEN);
  localparam logic [VALUE_CNT_W-1:0] VALUE_MAX = VALUE_CNT_W'(VALUE_MAX_LEN);

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_end;

  // parser state
  phase_t                 phase, phase_next;
  logic [NAME_CNT_W-1:0]  name_count, name_count_next;
  logic [NAME_CNT_W-1:0]  name_trim, name_trim_next;
  logic [VALUE_CNT_W-1:0] value_count, value_count_next;
  logic [VALUE_CNT_W-1:0] value_trim, value_trim_next;

  // result register
  logic                   res_valid;
  role_t                  res_role, res_role_next;
  logic [BYTE_W-1:0]      res_byte;
  status_t                res_status, res_status_next;
  logic                   res_hv, res_hv_next;
  logic [NAME_LEN_W-1:0]  res_name_len, res_name_len_next;
  logic [VALUE_LEN_W-1:0] res_value_len, res_value_len_next;
  logic                   res_end;

  logic res_load, in_adv;

  assign res_load    = !res_valid || tokens.ready;
  assign in_adv      = in_valid && res_load;
  assign bytes.ready = !in_valid || res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
    if (bytes.ready && bytes.valid) begin
      in_byte <= bytes.data_byte;
      in_end  <= bytes.buffer_end;
    end
  end

  always_comb begin
    logic b_blank, done, err, hv, vbyte;
    phase_t ph;

    b_blank          = is_blank(in_byte);
    done             = 1'b0;
    err              = 1'b0;
    hv               = 1'b0;
    vbyte            = 1'b0;
    ph               = phase;
    name_count_next  = name_count;
    name_trim_next   = name_trim;
    value_count_next = value_count;
    value_trim_next  = value_trim;
    res_role_next    = ROLE_SKIP;

    // first non-separator byte opens a name
    if (phase == PH_SKIP && !(in_byte == CH_COMMA || b_blank)) begin
      name_count_next = '0;
      name_trim_next  = '0;
      ph              = PH_NAME;
    end

    unique case (ph)
      PH_NAME: begin
        if (in_byte == CH_COMMA || in_byte == CH_CR || in_byte == CH_LF) begin
          done = 1'b1;
        end else if (in_byte == CH_EQUAL || in_byte == CH_NUL) begin
          if (name_trim_next >= NAME_MAX) begin
            err = 1'b1;
          end else begin
            hv               = 1'b1;
            value_count_next = '0;
            value_trim_next  = '0;
            ph               = PH_VLEAD;
            done             = in_end;
          end
        end else begin
          res_role_next = ROLE_NAME;
          if (name_count_next < NAME_MAX) begin
            name_count_next = name_count_next + 1'b1;
          end
          if (!b_blank) begin
            name_trim_next = name_count_next;
          end
          done = in_end;
        end
        if (done && !hv && name_trim_next >= NAME_MAX) begin
          done = 1'b0;
          err  = 1'b1;
        end
      end
      PH_VLEAD: begin
        hv = 1'b1;
        if (b_blank && in_byte != CH_CR && in_byte != CH_LF) begin
          done = in_end;
        end else if (in_byte == CH_COMMA || in_byte == CH_CR) begin
          done = 1'b1;
        end else begin
          vbyte = 1'b1;
          ph    = (in_byte == CH_QUOTE) ? PH_QUOTED : PH_PLAIN;
          done  = in_end;
        end
      end
      PH_PLAIN: begin
        hv = 1'b1;
        if (in_byte == CH_COMMA || in_byte == CH_CR) begin
          done = 1'b1;
        end else begin
          vbyte = 1'b1;
          done  = in_end;
        end
      end
      PH_QUOTED: begin
        hv    = 1'b1;
        vbyte = 1'b1;
        if (in_byte == CH_QUOTE) begin
          ph = PH_AFTERQ;
        end
        done = in_end;
      end
      PH_AFTERQ: begin
        hv = 1'b1;
        if (in_byte == CH_COMMA || in_byte == CH_CR) begin
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (vbyte) begin
      res_role_next    = ROLE_VALUE;
      value_count_next = value_count_next + 1'b1;
      if (!b_blank) begin
        value_trim_next = value_count_next;
      end
      if (value_count_next >= VALUE_MAX) begin
        err = 1'b1;
      end
    end

    if (err) begin
      done          = 1'b0;
      res_role_next = ROLE_SKIP;
      ph            = PH_HALT;
    end else if (done) begin
      ph = PH_SKIP;
    end
    if (in_end) begin
      ph = PH_SKIP;
    end
    phase_next = ph;

    res_status_next    = err ? ST_ERROR : (done ? ST_PAIR : ST_NONE);
    res_hv_next        = done && hv;
    res_name_len_next  = done ? name_trim_next[NAME_LEN_W-1:0] : '0;
    res_value_len_next = (done && hv) ? VALUE_LEN_W'(value_trim_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      name_count  <= '0;
      name_trim   <= '0;
      value_count <= '0;
      value_trim  <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (in_adv) begin
        phase       <= phase_next;
        name_count  <= name_count_next;
        name_trim   <= name_trim_next;
        value_count <= value_count_next;
        value_trim  <= value_trim_next;
      end
      if (res_load) begin
        res_valid <= in_valid;
      end
    end
    if (in_adv) begin
      res_role      <= res_role_next;
      res_byte      <= in_byte;
      res_status    <= res_status_next;
      res_hv        <= res_hv_next;
      res_name_len  <= res_name_len_next;
      res_value_len <= res_value_len_next;
      res_end       <= in_end;
    end
  end

  assign tokens.valid        = res_valid;
  assign tokens.byte_role    = res_role;
  assign tokens.echo_byte    = res_byte;
  assign tokens.status       = res_status;
  assign tokens.has_value    = res_hv;
  assign tokens.name_length  = res_name_len;
  assign tokens.value_length = res_value_len;
  assign tokens.end_seen     = res_end;

  a_end_resumes_skip: assert property (@(posedge clk) disable iff (rst)
    (in_adv && in_end) |=> (phase == PH_SKIP))
    else $error("buffer end did not return parser to skip");

  a_error_no_role: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == ST_ERROR) |-> (res_role == ROLE_SKIP && !res_hv))
    else $error("error result carries a role or value flag");

  a_value_needs_pair: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_hv) |-> (res_status == ST_PAIR))
    else $error("has_value without a completed pair");

  a_name_saturates: assert property (@(posedge clk) disable iff (rst)
    (name_count <= NAME_MAX) && (name_trim <= name_count))
    else $error("name counter out of range");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_adv && phase == PH_HALT) |=> (res_status == ST_NONE && res_role == ROLE_SKIP))
    else $error("byte after error produced output");

endmodule
